>>> hw/rtl/bta_pkg.sv
// bta_pkg: shared types, constants and helpers of the buddy tree allocator
// used by bta_alu, bta_tree_mem and buddy_tree_allocator; no dependencies
`timescale 1ns / 1ps

package bta_pkg;

  localparam int REQ_W   = 12;
  localparam int OFF_W   = 7;
  localparam int EXP_W   = 4;
  localparam int MIN_EXP = 3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_LE
  } alu_op_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // exponent of the request rounded up to a power of two, never below MIN_EXP (3)
  function automatic logic [EXP_W-1:0] size_exp(input logic [REQ_W-1:0] req);
    logic [REQ_W-1:0] m;
    logic [EXP_W-1:0] e;
    m = req - REQ_W'(1);
    e = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (m[i]) begin
        e = EXP_W'(i + 1);
      end
    end
    if (req <= REQ_W'(8)) begin
      e = EXP_W'(MIN_EXP);
    end
    return e;
  endfunction

endpackage

>>> hw/rtl/buddy_tree_allocator.sv
// buddy_tree_allocator: buddy allocator kept as a binary tree of used counts
// uses bta_pkg, bta_alu and bta_tree_mem
//
// channel   ports                                          handshake
// input     in_func, in_request_size, in_block_offset      start && !busy
// result    out_status, out_granted_offset                 out_valid, one cycle
//
// allocate: load root; per level check, read children, pick; overflow rolls back
// free: one update per node from the leaf to the root (LEVELS nodes)
// oversized request or out-of-range free: answered straight from idle
// result fields and strobe are registered; all arithmetic shares one alu
// after reset a clearing pass over all 2**LEVELS-1 nodes holds busy high
// the receiver cannot stall; every result is taken in its strobe cycle
`timescale 1ns / 1ps

module buddy_tree_allocator #(
  parameter int LEVELS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_func,
  input  logic [bta_pkg::REQ_W-1:0]  in_request_size,
  input  logic [bta_pkg::OFF_W-1:0]  in_block_offset,
  output logic                       out_valid,
  output logic                       out_status,
  output logic [bta_pkg::OFF_W-1:0]  out_granted_offset
);

  localparam int UNITS = 2 ** (LEVELS - 1);
  localparam int NODES = 2 * UNITS - 1;
  localparam int POOL  = UNITS * 8;
  localparam int NW    = LEVELS;
  localparam int UW    = LEVELS + 3;
  localparam int EW    = UW + 1;
  localparam int UNW   = LEVELS - 1;
  localparam int DPW   = $clog2(LEVELS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_A_LD  = 4'd2;
  localparam logic [3:0] S_A_CHK = 4'd3;
  localparam logic [3:0] S_A_RDR = 4'd4;
  localparam logic [3:0] S_A_PCK = 4'd5;
  localparam logic [3:0] S_RB_WR = 4'd6;
  localparam logic [3:0] S_F_WR  = 4'd7;

  logic [3:0]     state_r, state_nxt;
  logic [NW-1:0]  node_r, node_nxt;
  logic [NW-1:0]  clr_r, clr_nxt;
  logic [DPW-1:0] depth_r, depth_nxt;
  logic [DPW-1:0] tdepth_r, tdepth_nxt;
  logic [UNW-1:0] unit_r, unit_nxt;
  logic [UW-1:0]  bytes_r, bytes_nxt;
  logic [UW-1:0]  size_r, size_nxt;
  logic [UW-1:0]  amount_r, amount_nxt;
  logic [EW-1:0]  cur_r, cur_nxt;
  logic [EW-1:0]  left_r, left_nxt;
  logic           found_r, found_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_status_r, out_status_nxt;
  logic [bta_pkg::OFF_W-1:0] out_granted_r, out_granted_nxt;

  bta_pkg::mem_ctl_t mem_ctl;
  logic [NW-1:0]     wr_addr, rd_addr;
  logic [EW-1:0]     wr_data, rd_data;

  bta_pkg::alu_op_t alu_op;
  logic [UW-1:0]    alu_a, alu_b, alu_lim, alu_res;
  logic             alu_flag;

  logic [NW-1:0]    parent, lchild, rchild;
  logic [UW-1:0]    cap;
  logic [UNW-1:0]   inc;
  logic [bta_pkg::EXP_W-1:0] req_exp;
  logic             accept;
  logic             hit;

  bta_tree_mem #(
    .AW    (NW),
    .DW    (EW),
    .DEPTH (NODES)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bta_alu #(
    .W (UW)
  ) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .lim  (alu_lim),
    .res  (alu_res),
    .flag (alu_flag)
  );

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign parent  = (node_r - NW'(1)) >> 1;
  assign lchild  = (node_r << 1) + NW'(1);
  assign rchild  = (node_r << 1) + NW'(2);
  assign cap     = UW'(POOL) >> depth_r;
  assign inc     = UNW'(UNITS / 2) >> depth_r;
  assign req_exp = bta_pkg::size_exp(in_request_size);
  assign hit     = !found_r && rd_data[UW];

  always_comb begin
    state_nxt       = state_r;
    node_nxt        = node_r;
    clr_nxt         = clr_r;
    depth_nxt       = depth_r;
    tdepth_nxt      = tdepth_r;
    unit_nxt        = unit_r;
    bytes_nxt       = bytes_r;
    size_nxt        = size_r;
    amount_nxt      = amount_r;
    cur_nxt         = cur_r;
    left_nxt        = left_r;
    found_nxt       = found_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    mem_ctl         = '0;
    wr_addr         = node_r;
    wr_data         = '0;
    rd_addr         = node_r;
    alu_op          = bta_pkg::ALU_SUB;
    alu_a           = rd_data[UW-1:0];
    alu_b           = bytes_r;
    alu_lim         = cap;

    unique case (state_r)
      S_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = clr_r;
        wr_data       = '0;
        if (clr_r == NW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + NW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          if (in_func == bta_pkg::FUNC_FREE) begin
            if (32'(in_block_offset) >= UNITS) begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = bta_pkg::STATUS_OK;
              out_granted_nxt = '0;
            end else begin
              node_nxt       = NW'(32'(in_block_offset) + UNITS - 1);
              mem_ctl.rd_en  = 1'b1;
              rd_addr        = node_nxt;
              found_nxt      = 1'b0;
              size_nxt       = UW'(8);
              state_nxt      = S_F_WR;
            end
          end else begin
            if (int'(req_exp) > LEVELS + 2) begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = bta_pkg::STATUS_FAIL;
              out_granted_nxt = '0;
            end else begin
              bytes_nxt     = UW'(1) << req_exp;
              tdepth_nxt    = DPW'(LEVELS + 2 - int'(req_exp));
              node_nxt      = '0;
              depth_nxt     = '0;
              unit_nxt      = '0;
              mem_ctl.rd_en = 1'b1;
              rd_addr       = '0;
              state_nxt     = S_A_LD;
            end
          end
        end
      end

      S_A_LD: begin
        cur_nxt   = rd_data;
        state_nxt = S_A_CHK;
      end

      S_A_CHK: begin
        alu_op = bta_pkg::ALU_ADD;
        alu_a  = cur_r[UW-1:0];
        alu_b  = bytes_r;
        priority if (alu_flag && node_r == '0) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = bta_pkg::STATUS_FAIL;
          out_granted_nxt = '0;
          state_nxt       = S_IDLE;
        end else if (alu_flag) begin
          node_nxt      = parent;
          mem_ctl.rd_en = 1'b1;
          rd_addr       = parent;
          state_nxt     = S_RB_WR;
        end else begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = node_r;
          wr_data       = {cur_r[UW] | (depth_r == tdepth_r), alu_res};
          if (depth_r == tdepth_r) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = bta_pkg::STATUS_OK;
            out_granted_nxt = bta_pkg::OFF_W'(32'(unit_r));
            state_nxt       = S_IDLE;
          end else begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = lchild;
            state_nxt     = S_A_RDR;
          end
        end
      end

      S_A_RDR: begin
        left_nxt      = rd_data;
        mem_ctl.rd_en = 1'b1;
        rd_addr       = rchild;
        state_nxt     = S_A_PCK;
      end

      S_A_PCK: begin
        alu_op = bta_pkg::ALU_LE;
        alu_a  = left_r[UW-1:0];
        alu_b  = rd_data[UW-1:0];
        if (alu_flag) begin
          node_nxt = lchild;
          cur_nxt  = left_r;
        end else begin
          node_nxt = rchild;
          cur_nxt  = rd_data;
          unit_nxt = unit_r + inc;
        end
        depth_nxt = depth_r + DPW'(1);
        state_nxt = S_A_CHK;
      end

      S_RB_WR: begin
        alu_op        = bta_pkg::ALU_SUB;
        alu_a         = rd_data[UW-1:0];
        alu_b         = bytes_r;
        mem_ctl.wr_en = 1'b1;
        wr_addr       = node_r;
        wr_data       = {rd_data[UW], alu_res};
        if (node_r == '0) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = bta_pkg::STATUS_FAIL;
          out_granted_nxt = '0;
          state_nxt       = S_IDLE;
        end else begin
          node_nxt      = parent;
          mem_ctl.rd_en = 1'b1;
          rd_addr       = parent;
        end
      end

      S_F_WR: begin
        alu_op        = bta_pkg::ALU_SUB;
        alu_a         = rd_data[UW-1:0];
        alu_b         = found_r ? amount_r : size_r;
        mem_ctl.wr_en = found_r || hit;
        wr_addr       = node_r;
        wr_data       = {found_r ? rd_data[UW] : 1'b0, alu_res};
        if (hit) begin
          found_nxt  = 1'b1;
          amount_nxt = size_r;
        end
        if (node_r == '0) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = bta_pkg::STATUS_OK;
          out_granted_nxt = '0;
          state_nxt       = S_IDLE;
        end else begin
          node_nxt      = parent;
          mem_ctl.rd_en = 1'b1;
          rd_addr       = parent;
          size_nxt      = size_r << 1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r        <= node_nxt;
    depth_r       <= depth_nxt;
    tdepth_r      <= tdepth_nxt;
    unit_r        <= unit_nxt;
    bytes_r       <= bytes_nxt;
    size_r        <= size_nxt;
    amount_r      <= amount_nxt;
    cur_r         <= cur_nxt;
    left_r        <= left_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_granted_r;

  // every accepted transaction either reports next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted transaction neither reported nor in progress");

  // a failed allocation never reports an offset
  a_fail_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bta_pkg::STATUS_FAIL) |-> (out_granted_offset == '0))
    else $error("failed allocation with nonzero offset");

  // no result while the store is being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result during clearing pass");

  // store writes stay inside the tree
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |-> (32'(wr_addr) <= NODES - 1))
    else $error("tree store write out of range");

endmodule

>>> hw/rtl/bta_alu.sv
// bta_alu: shared add / subtract / compare unit of the allocator
// depends on bta_pkg for the operation codes
`timescale 1ns / 1ps

module bta_alu #(
  parameter int W = 11
) (
  input  bta_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  input  logic [W-1:0]     lim,
  output logic [W-1:0]     res,
  output logic             flag
);

  logic [W:0] sum;

  always_comb begin
    sum  = {1'b0, a} + {1'b0, b};
    res  = '0;
    flag = 1'b0;
    unique case (op)
      bta_pkg::ALU_ADD: begin
        res  = sum[W-1:0];
        flag = (sum > {1'b0, lim});
      end
      bta_pkg::ALU_SUB: begin
        res = a - b;
      end
      bta_pkg::ALU_LE: begin
        flag = (a <= b);
      end
      default: begin
        res  = '0;
        flag = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/bta_tree_mem.sv
// bta_tree_mem: node store of the buddy tree, one write and one read port
// read data registered; depends on bta_pkg for the port control struct
`timescale 1ns / 1ps

module bta_tree_mem #(
  parameter int AW    = 8,
  parameter int DW    = 12,
  parameter int DEPTH = 255
) (
  input  logic              clk,
  input  bta_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DW-1:0]     wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DW-1:0]     rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sim/bta_check_pkg.sv
// bta_check_pkg: allocation tree predictor and result scoreboard for the buddy tree allocator
// depends on bta_pkg for field widths, function codes and status codes
`timescale 1ns / 1ps

package bta_check_pkg;

  localparam int LEVELS     = 8;
  localparam int UNITS      = 1 << (LEVELS - 1);
  localparam int NODES      = 2 * UNITS - 1;
  localparam int UNIT_BYTES = 8;
  localparam int POOL_BYTES = UNITS * UNIT_BYTES;

  class alloc_scoreboard;
    logic [10:0]               used_bytes[NODES];
    bit                        taken_mark[NODES];
    logic                      exp_status[$];
    logic [bta_pkg::OFF_W-1:0] exp_offset[$];
    int                        errors;
    int                        results_seen;

    function new();
      foreach (used_bytes[i]) begin
        used_bytes[i] = '0;
        taken_mark[i] = 1'b0;
      end
      errors = 0;
      results_seen = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("ERROR: result %0d: %s", results_seen, msg);
      errors++;
    endtask

    function int unsigned outstanding();
      return exp_status.size();
    endfunction

    function int unsigned pool_used();
      return used_bytes[0];
    endfunction

    // descend toward the less-used child, undo the partial sums on failure
    function logic grant_block(input int unsigned blk_bytes,
                               output logic [bta_pkg::OFF_W-1:0] unit_off);
      int unsigned node, depth, cap, first_unit, left, right;
      node = 0;
      first_unit = 0;
      unit_off = '0;
      for (depth = 0; depth < LEVELS; depth++) begin
        cap = POOL_BYTES >> depth;
        if (used_bytes[node] + blk_bytes > cap) begin
          while (node != 0) begin
            node = (node - 1) >> 1;
            used_bytes[node] -= blk_bytes;
          end
          return bta_pkg::STATUS_FAIL;
        end
        used_bytes[node] += blk_bytes;
        if (blk_bytes == cap || depth + 1 >= LEVELS) begin
          taken_mark[node] = 1'b1;
          unit_off = bta_pkg::OFF_W'(first_unit);
          return bta_pkg::STATUS_OK;
        end
        left = 2 * node + 1;
        right = left + 1;
        if (used_bytes[left] <= used_bytes[right]) begin
          node = left;
        end else begin
          node = right;
          first_unit += (UNITS >> 1) >> depth;
        end
      end
      return bta_pkg::STATUS_FAIL;
    endfunction

    // climb from the leaf, clear the first mark and subtract its size upward
    function void release_block(input logic [bta_pkg::OFF_W-1:0] off);
      int unsigned node, blk_bytes, amount;
      bit found;
      if (int'(off) >= UNITS) begin
        return;
      end
      node = off + UNITS - 1;
      blk_bytes = UNIT_BYTES;
      found = 1'b0;
      amount = 0;
      forever begin
        if (!found && taken_mark[node]) begin
          taken_mark[node] = 1'b0;
          found = 1'b1;
          amount = blk_bytes;
        end
        if (found) begin
          used_bytes[node] -= amount;
        end
        if (node == 0) begin
          break;
        end
        node = (node - 1) >> 1;
        blk_bytes <<= 1;
      end
    endfunction

    function void note_request(input logic func, input logic [bta_pkg::REQ_W-1:0] req,
                               input logic [bta_pkg::OFF_W-1:0] off, output logic status,
                               output logic [bta_pkg::OFF_W-1:0] granted,
                               output int unsigned units);
      int unsigned blk_bytes;
      status = bta_pkg::STATUS_OK;
      granted = '0;
      units = 0;
      if (func == bta_pkg::FUNC_ALLOC) begin
        blk_bytes = UNIT_BYTES;
        while (blk_bytes < req) begin
          blk_bytes <<= 1;
        end
        if (blk_bytes > POOL_BYTES) begin
          status = bta_pkg::STATUS_FAIL;
        end else begin
          status = grant_block(blk_bytes, granted);
          if (status == bta_pkg::STATUS_FAIL) begin
            granted = '0;
          end else begin
            units = blk_bytes / UNIT_BYTES;
          end
        end
      end else begin
        release_block(off);
      end
      exp_status.push_back(status);
      exp_offset.push_back(granted);
    endfunction

    task check_result(input logic status, input logic [bta_pkg::OFF_W-1:0] granted);
      logic                      status_exp;
      logic [bta_pkg::OFF_W-1:0] offset_exp;
      results_seen++;
      if (exp_status.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, status %0b offset %0d",
                                  status, granted));
        return;
      end
      status_exp = exp_status.pop_front();
      offset_exp = exp_offset.pop_front();
      if (status !== status_exp) begin
        report_mismatch($sformatf("status %0b, expected %0b", status, status_exp));
      end
      if (granted !== offset_exp) begin
        report_mismatch($sformatf("granted_offset %0d, expected %0d", granted, offset_exp));
      end
    endtask
  endclass

endpackage

>>> sim/buddy_tree_allocator_test.sv
// buddy_tree_allocator_test: directed and random allocate/free traffic against a tree predictor
// depends on bta_pkg, bta_check_pkg and the buddy_tree_allocator rtl
`timescale 1ns / 1ps

module buddy_tree_allocator_test;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1530;
  localparam int DRAIN_CYCLES = 40;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_func;
  logic [bta_pkg::REQ_W-1:0] in_request_size;
  logic [bta_pkg::OFF_W-1:0] in_block_offset;
  logic                      out_valid;
  logic                      out_status;
  logic [bta_pkg::OFF_W-1:0] out_granted_offset;

  bta_check_pkg::alloc_scoreboard sb;
  int unsigned     stall_cycles;
  int unsigned     live_off[$];
  int unsigned     live_units[$];

  buddy_tree_allocator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_request_size    (in_request_size),
    .in_block_offset    (in_block_offset),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_offset (out_granted_offset)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      sb.check_result(out_status, out_granted_offset);
    end
  end

  always @(posedge clk) begin
    if ((rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input logic func, input logic [bta_pkg::REQ_W-1:0] req,
                              input logic [bta_pkg::OFF_W-1:0] off);
    logic                      status;
    logic [bta_pkg::OFF_W-1:0] granted;
    int unsigned               units;
    @(negedge clk);
    start = 1'b1;
    in_func = func;
    in_request_size = req;
    in_block_offset = off;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(func, req, off, status, granted, units);
    if (func == bta_pkg::FUNC_ALLOC && status == bta_pkg::STATUS_OK) begin
      live_off.push_back(granted);
      live_units.push_back(units);
    end
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      in_func = 1'($urandom);
      in_request_size = bta_pkg::REQ_W'($urandom);
      in_block_offset = bta_pkg::OFF_W'($urandom);
    end
  endtask

  // mostly frees of live blocks and allocations of small sizes, some noise
  task automatic random_request(output logic func, output logic [bta_pkg::REQ_W-1:0] req,
                                output logic [bta_pkg::OFF_W-1:0] off);
    int unsigned pick, free_pct, idx;
    pick = $urandom_range(99);
    free_pct = (sb.pool_used() > 768) ? 75 : 35;
    func = bta_pkg::FUNC_ALLOC;
    req = bta_pkg::REQ_W'($urandom);
    off = bta_pkg::OFF_W'($urandom);
    if (pick < 8) begin
      func = 1'($urandom);
    end else if (live_off.size() != 0 && $urandom_range(99) < free_pct) begin
      idx = $urandom_range(live_off.size() - 1);
      func = bta_pkg::FUNC_FREE;
      off = bta_pkg::OFF_W'(live_off[idx]);
      if ($urandom_range(3) == 0) begin
        off = bta_pkg::OFF_W'(live_off[idx] + $urandom_range(live_units[idx] - 1));
      end
      live_off.delete(idx);
      live_units.delete(idx);
    end else begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        req = bta_pkg::REQ_W'($urandom_range(64));
      end else if (pick < 85) begin
        req = bta_pkg::REQ_W'($urandom_range(256, 65));
      end else if (pick < 95) begin
        req = bta_pkg::REQ_W'($urandom_range(1024, 257));
      end else begin
        req = bta_pkg::REQ_W'($urandom_range(4095, 1025));
      end
    end
  endtask

  initial begin
    logic                      f;
    logic [bta_pkg::REQ_W-1:0] r;
    logic [bta_pkg::OFF_W-1:0] o;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = bta_pkg::FUNC_ALLOC;
    in_request_size = '0;
    in_block_offset = '0;
    stall_cycles = 0;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // oversized, whole pool, full pool, frees inside and outside blocks
    send_request(bta_pkg::FUNC_ALLOC, 12'd4095, 7'd0);
    send_request(bta_pkg::FUNC_ALLOC, 12'd1025, 7'd127);
    send_request(bta_pkg::FUNC_ALLOC, 12'd1024, 7'd0);
    send_request(bta_pkg::FUNC_ALLOC, 12'd0, 7'd0);
    send_request(bta_pkg::FUNC_FREE, 12'd4095, 7'd77);
    send_request(bta_pkg::FUNC_FREE, 12'd0, 7'd77);
    send_request(bta_pkg::FUNC_FREE, 12'd0, 7'd127);
    // two small blocks split the halves, then a half-pool request fails
    send_request(bta_pkg::FUNC_ALLOC, 12'd8, 7'd0);
    send_request(bta_pkg::FUNC_ALLOC, 12'd1, 7'd0);
    send_request(bta_pkg::FUNC_ALLOC, 12'd512, 7'd0);
    send_request(bta_pkg::FUNC_FREE, 12'd0, 7'd0);
    send_request(bta_pkg::FUNC_FREE, 12'd0, 7'd64);
    send_request(bta_pkg::FUNC_ALLOC, 12'd512, 7'd0);
    send_request(bta_pkg::FUNC_ALLOC, 12'd513, 7'd0);
    send_request(bta_pkg::FUNC_ALLOC, 12'd9, 7'd127);
    send_request(bta_pkg::FUNC_ALLOC, 12'd256, 7'd0);
    send_request(bta_pkg::FUNC_ALLOC, 12'd2048, 7'd0);
    send_request(bta_pkg::FUNC_FREE, 12'd0, 7'd97);
    send_request(bta_pkg::FUNC_FREE, 12'd0, 7'd65);
    send_request(bta_pkg::FUNC_FREE, 12'd0, 7'd0);
    send_request(bta_pkg::FUNC_FREE, 12'd0, 7'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ((i < 500 || i >= 900) && $urandom_range(99) < 9) begin
        idle_cycles(1);
      end
      random_request(f, r, o);
      send_request(f, r, o);
    end
    @(negedge clk);
    start = 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
